### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("%m: assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/core/vlpf_pkg.sv
// ----------------------------------------------------------------------------
// vlpf_pkg
// Types and constants shared by the varint length packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package vlpf_pkg;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	localparam int unsigned HDR_LEN    = 4;
	localparam int unsigned TAIL_LEN   = 4;
	localparam int unsigned MAX_DIGITS = 3;
	localparam int unsigned DIGIT_BITS = 7;
	localparam int unsigned LEN_BIAS   = 4;
	// wide enough for the largest length plus bias
	localparam int unsigned VARINT_W   = MAX_DIGITS * DIGIT_BITS + 1;

	localparam logic [7:0] HDR_ZERO  = 8'h00;
	localparam logic [7:0] HDR_TAG   = 8'h03;
	localparam logic [7:0] FLAG_BYTE = 8'h00;
	localparam logic [7:0] CMD_HI    = 8'h00;
	localparam logic [7:0] CMD_LO    = 8'h91;
	localparam logic [7:0] ERR_BYTE  = 8'h00;

	// byte position within one item's output burst (at most 11 bytes)
	typedef logic [3:0] idx_t;

	typedef struct packed {
		logic [MAX_DIGITS-1:0][7:0] digit;
		logic [1:0]                 count;
	} varint_t;

endpackage

`default_nettype wire

### rtl/core/vlpf_varint_enc.sv
// ----------------------------------------------------------------------------
// vlpf_varint_enc
// Base-128 little-endian encoder for the frame length (payload + 4).
// ----------------------------------------------------------------------------
`default_nettype none

module vlpf_varint_enc #(
	parameter int unsigned LEN_BITS = 16
) (
	input  wire logic [LEN_BITS-1:0] plen,
	output vlpf_pkg::varint_t        enc
);

	logic [vlpf_pkg::VARINT_W-1:0]   len;
	logic [vlpf_pkg::MAX_DIGITS-1:0] more;

	assign len = vlpf_pkg::VARINT_W'(plen) + vlpf_pkg::VARINT_W'(vlpf_pkg::LEN_BIAS);

	always_comb begin
		for (int i = 0; i < vlpf_pkg::MAX_DIGITS; i++) begin
			// continuation set while higher digits remain
			more[i] = |(len >> (vlpf_pkg::DIGIT_BITS * (i + 1)));
			enc.digit[i] = {more[i], len[vlpf_pkg::DIGIT_BITS*i +: vlpf_pkg::DIGIT_BITS]};
		end
		priority if (more[1]) begin
			enc.count = 2'd3;
		end else if (more[0]) begin
			enc.count = 2'd2;
		end else begin
			enc.count = 2'd1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/varint_length_packet_framer_core.sv
// ----------------------------------------------------------------------------
// varint_length_packet_framer_core
// Emits framed packets byte by byte from start and payload items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): op = 0 starts a frame with action and
//   payload_len; op = 1 carries one payload byte in data_byte.
//   Output channel (out_valid/out_ready): one item per frame byte, with last
//   on the final byte and error on a payload byte that has no open frame.
//   A start item yields 9 to 11 bytes: 00 00 00 03, the varint of
//   payload_len + 4 (one to three digits), then 00 00 91 and the action.
//   Pipeline: an accepted item loads the work stage on the accepting edge, and
//   its first byte then enters the output register once that can take a byte.
//   Throughput: one output byte per cycle while out_ready allows, set by the
//   single byte sequencer in the work stage, so payload items flow at one per
//   cycle and a start item holds the input until its 9 to 11 bytes are loaded.
//   The next item is taken in the cycle the current one sends its last byte.
//   Stall: when out_ready is low the output register holds its byte, the
//   work stage holds its position and in_ready drops once it is occupied.
//   Reset (arst_n low) empties both stages and closes any open frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module varint_length_packet_framer_core #(
	parameter int unsigned LEN_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [7:0]  action,
	input  wire logic [15:0] payload_len,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             error
);

	// ---- input side ----
	logic                    in_fire;
	logic [LEN_BITS-1:0]     plen_in;
	vlpf_pkg::varint_t       enc_in;
	vlpf_pkg::idx_t          last_idx_in;

	// ---- work stage: one item being expanded ----
	logic                    busy_s1;
	vlpf_pkg::op_t           op_s1;
	logic [7:0]              action_s1;
	logic [LEN_BITS-1:0]     plen_s1;
	logic [7:0]              data_s1;
	vlpf_pkg::varint_t       enc_s1;
	vlpf_pkg::idx_t          idx_s1;
	vlpf_pkg::idx_t          last_idx_s1;

	// ---- frame state ----
	logic [LEN_BITS-1:0]     bytes_left_q;
	logic                    frame_open_q;

	// ---- byte selection ----
	logic                    out_load;
	logic                    item_done;
	logic                    pay_err;
	vlpf_pkg::idx_t          digit_end;
	vlpf_pkg::idx_t          digit_off;
	vlpf_pkg::idx_t          tail_off;
	logic [7:0]              nxt_byte;
	logic                    nxt_last;
	logic                    nxt_err;

	// ---- output register ----
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    last_q;
	logic                    error_q;

	// Only the low LEN_BITS of the length count.
	assign plen_in = LEN_BITS'(payload_len);

	vlpf_varint_enc #(
		.LEN_BITS (LEN_BITS)
	) u_enc (
		.plen (plen_in),
		.enc  (enc_in)
	);

	// A start item spans header, varint digits and tail; a payload item one byte.
	assign last_idx_in = (vlpf_pkg::op_t'(op) == vlpf_pkg::OP_START)
		? vlpf_pkg::idx_t'(vlpf_pkg::HDR_LEN + vlpf_pkg::TAIL_LEN - 1)
			+ vlpf_pkg::idx_t'(enc_in.count)
		: '0;

	// Advance the work stage whenever the output register can take a byte.
	assign out_load  = busy_s1 && (!out_valid_q || out_ready);
	assign item_done = out_load && (idx_s1 == last_idx_s1);
	assign in_ready  = !busy_s1 || item_done;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= '0;
		end else if (in_fire) begin
			busy_s1 <= 1'b1;
			idx_s1  <= '0;
		end else if (item_done) begin
			busy_s1 <= 1'b0;
		end else if (out_load) begin
			idx_s1 <= idx_s1 + vlpf_pkg::idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1       <= vlpf_pkg::op_t'(op);
			action_s1   <= action;
			plen_s1     <= plen_in;
			data_s1     <= data_byte;
			enc_s1      <= enc_in;
			last_idx_s1 <= last_idx_in;
		end
	end

	// Position of the current byte relative to the digits and to the tail.
	assign digit_end = vlpf_pkg::idx_t'(vlpf_pkg::HDR_LEN) + vlpf_pkg::idx_t'(enc_s1.count);
	assign digit_off = idx_s1 - vlpf_pkg::idx_t'(vlpf_pkg::HDR_LEN);
	assign tail_off  = idx_s1 - digit_end;

	// A payload byte needs an open frame with bytes still owed.
	assign pay_err = !frame_open_q || (bytes_left_q == '0);

	always_comb begin
		nxt_byte = vlpf_pkg::HDR_ZERO;
		nxt_last = 1'b0;
		nxt_err  = 1'b0;
		unique case (op_s1)
			vlpf_pkg::OP_START: begin
				if (idx_s1 < vlpf_pkg::idx_t'(vlpf_pkg::HDR_LEN)) begin
					nxt_byte = (idx_s1 == vlpf_pkg::idx_t'(vlpf_pkg::HDR_LEN - 1))
						? vlpf_pkg::HDR_TAG : vlpf_pkg::HDR_ZERO;
				end else if (idx_s1 < digit_end) begin
					unique case (digit_off[1:0])
						2'd0:    nxt_byte = enc_s1.digit[0];
						2'd1:    nxt_byte = enc_s1.digit[1];
						2'd2:    nxt_byte = enc_s1.digit[2];
						default: nxt_byte = vlpf_pkg::HDR_ZERO;
					endcase
				end else begin
					unique case (tail_off[1:0])
						2'd0: nxt_byte = vlpf_pkg::FLAG_BYTE;
						2'd1: nxt_byte = vlpf_pkg::CMD_HI;
						2'd2: nxt_byte = vlpf_pkg::CMD_LO;
						2'd3: begin
							// empty payload: the action byte closes the frame
							nxt_byte = action_s1;
							nxt_last = (plen_s1 == '0);
						end
					endcase
				end
			end
			vlpf_pkg::OP_PAYLOAD: begin
				if (pay_err) begin
					nxt_byte = vlpf_pkg::ERR_BYTE;
					nxt_err  = 1'b1;
				end else begin
					nxt_byte = data_s1;
					nxt_last = (bytes_left_q == LEN_BITS'(1));
				end
			end
		endcase
	end

	// Frame state moves at most once per item, when its final byte leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			frame_open_q <= 1'b0;
		end else if (item_done) begin
			if (op_s1 == vlpf_pkg::OP_START) begin
				// a start drops any frame still open
				bytes_left_q <= plen_s1;
				frame_open_q <= (plen_s1 != '0);
			end else if (!pay_err) begin
				bytes_left_q <= bytes_left_q - LEN_BITS'(1);
				if (bytes_left_q == LEN_BITS'(1)) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

	// Output register: load a byte or drain on ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= nxt_byte;
			last_q     <= nxt_last;
			error_q    <= nxt_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign error     = error_q;

	// ---- checks ----
	`ASSERT_PROP(a_open_has_bytes, clk, arst_n, frame_open_q |-> (bytes_left_q != '0))
	`ASSERT_PROP(a_idx_in_range, clk, arst_n, busy_s1 |-> (idx_s1 <= last_idx_s1))
	`ASSERT_PROP(a_err_byte_clean, clk, arst_n,
		(out_valid_q && error_q) |-> ((out_byte_q == vlpf_pkg::ERR_BYTE) && !last_q))
	`ASSERT_PROP(a_start_opens, clk, arst_n,
		(item_done && (op_s1 == vlpf_pkg::OP_START) && (plen_s1 != '0)) |=> frame_open_q)

endmodule

`default_nettype wire
